[sv/assert_macros.svh]
// Assertion macros shared by the LED nibble blink sequencer RTL.
// Each macro assumes clk and rst_n exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define LNBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define LNBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lnbs_pkg.sv]
// Shared types and constants for the LED nibble blink sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none
package lnbs_pkg;

  localparam int VALUE_BITS = 32;
  localparam int DUR_W      = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [31:0] VAL_MASK = 32'hFFFF_FFFF >> (32 - VALUE_BITS);

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_ZIP_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_GAP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_GAP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_FRAME = 3'd4;

  localparam logic [DUR_W-1:0] RST_ZIP_STEP   = 16'd20;
  localparam logic [DUR_W-1:0] RST_NIBBLE_GAP = 16'd500;
  localparam logic [DUR_W-1:0] RST_WORD_GAP   = 16'd200;
  localparam logic [DUR_W-1:0] RST_SHOW       = 16'd2000;
  localparam logic [DUR_W-1:0] RST_ZERO_FRAME = 16'd900;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [1:0] MODE_8  = 2'd0;
  localparam logic [1:0] MODE_16 = 2'd1;
  localparam logic [1:0] MODE_32 = 2'd2;

  typedef struct packed {
    logic [DUR_W-1:0] zip_step_ms;
    logic [DUR_W-1:0] nibble_gap_ms;
    logic [DUR_W-1:0] word_gap_ms;
    logic [DUR_W-1:0] show_ms;
    logic [DUR_W-1:0] zero_frame_ms;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [31:0] value_in;
    logic [1:0]  width_sel;
    logic        start_pause;
  } in_word_t;

  typedef struct packed {
    logic [3:0] led_pattern;
    logic       busy_res;
    logic       finished;
  } res_word_t;

endpackage
`default_nettype wire

[sv/lnbs_cfg.sv]
// Duration register file of the LED nibble blink sequencer.
// Depends on lnbs_pkg.
`default_nettype none
module lnbs_cfg (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire [lnbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [lnbs_pkg::DUR_W-1:0]       cfg_data,
  output lnbs_pkg::cfg_t                  cfg
);
  import lnbs_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zip_step_ms   <= RST_ZIP_STEP;
      cfg_r.nibble_gap_ms <= RST_NIBBLE_GAP;
      cfg_r.word_gap_ms   <= RST_WORD_GAP;
      cfg_r.show_ms       <= RST_SHOW;
      cfg_r.zero_frame_ms <= RST_ZERO_FRAME;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ZIP_STEP:   cfg_r.zip_step_ms   <= cfg_data;
        CFG_NIBBLE_GAP: cfg_r.nibble_gap_ms <= cfg_data;
        CFG_WORD_GAP:   cfg_r.word_gap_ms   <= cfg_data;
        CFG_SHOW:       cfg_r.show_ms       <= cfg_data;
        CFG_ZERO_FRAME: cfg_r.zero_frame_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[sv/lnbs_core.sv]
// Sequencer state and one-step update: phase, tick countdown, nibble shifter, zips.
// Depends on lnbs_pkg and assert_macros.svh.
`default_nettype none
module lnbs_core (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        go,
  input  wire lnbs_pkg::in_word_t    word,
  input  wire lnbs_pkg::cfg_t        cfg,
  output lnbs_pkg::res_word_t        res
);
  import lnbs_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [4:0] {
    PH_IDLE, PH_LEAD, PH_SHOW, PH_ZPRE, PH_ZNIB, PH_ZPOST, PH_NGAP,
    PH_BPRE, PH_BZIP, PH_BPOST, PH_WPRE, PH_WZIP, PH_WPOST
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [3:0]  nibbles_r, nibbles_nxt;
  logic [1:0]  lamp_r, lamp_nxt;
  logic [2:0]  zips_r, zips_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [3:0]  lamps_r, lamps_nxt;
  logic        fin;

  logic [31:0] val_m, ld_shift, bn_src;
  logic [3:0]  ld_cnt, bn_cnt;
  logic [1:0]  ld_mode;
  logic [3:0]  nib;
  logic        is_start;
  logic [1:0]  lamp_inc;
  logic [2:0]  zips_dec;
  logic        wrap, last_zip;

  always_comb begin
    val_m   = word.value_in & VAL_MASK;
    ld_mode = (word.width_sel > MODE_32) ? MODE_32 : word.width_sel;
    case (ld_mode)
      MODE_8:  begin ld_shift = {val_m[7:0], 24'd0};  ld_cnt = 4'd2; end
      MODE_16: begin ld_shift = {val_m[15:0], 16'd0}; ld_cnt = 4'd4; end
      default: begin ld_shift = val_m;                ld_cnt = 4'd8; end
    endcase
    is_start = (word.op == OP_START);
    // next nibble comes from the freshly loaded value on a start
    bn_src   = is_start ? ld_shift : shift_r;
    bn_cnt   = is_start ? ld_cnt : nibbles_r;
    nib      = bn_src[31:28];
    lamp_inc = lamp_r + 2'd1;
    zips_dec = zips_r - 3'd1;
    wrap     = (lamp_inc == 2'd0);
    last_zip = wrap && (zips_dec == 3'd0);
  end

  always_comb begin
    phase_nxt   = phase_r;
    ticks_nxt   = ticks_r;
    shift_nxt   = shift_r;
    nibbles_nxt = nibbles_r;
    lamp_nxt    = lamp_r;
    zips_nxt    = zips_r;
    mode_nxt    = mode_r;
    lamps_nxt   = lamps_r;
    fin         = 1'b0;
    if (go) begin
      if (is_start) begin
        if (phase_r == PH_IDLE) begin
          mode_nxt = ld_mode;
          if (ld_mode == MODE_32 || word.start_pause) begin
            shift_nxt   = ld_shift;
            nibbles_nxt = ld_cnt;
            phase_nxt   = PH_LEAD;
            lamps_nxt   = 4'd0;
            ticks_nxt   = cfg.nibble_gap_ms;
          end else begin
            shift_nxt   = {bn_src[27:0], 4'd0};
            nibbles_nxt = bn_cnt - 4'd1;
            if (nib != 4'd0) begin
              phase_nxt = PH_SHOW; lamps_nxt = nib; ticks_nxt = cfg.show_ms;
            end else begin
              phase_nxt = PH_ZPRE; lamps_nxt = 4'd0; ticks_nxt = cfg.zero_frame_ms;
            end
          end
        end
      end else if (phase_r != PH_IDLE) begin
        if (ticks_r > 16'd1) begin
          ticks_nxt = ticks_r - 16'd1;
        end else begin
          case (phase_r)
            PH_LEAD, PH_NGAP, PH_BPOST, PH_WPOST: begin
              shift_nxt   = {bn_src[27:0], 4'd0};
              nibbles_nxt = bn_cnt - 4'd1;
              if (nib != 4'd0) begin
                phase_nxt = PH_SHOW; lamps_nxt = nib; ticks_nxt = cfg.show_ms;
              end else begin
                phase_nxt = PH_ZPRE; lamps_nxt = 4'd0; ticks_nxt = cfg.zero_frame_ms;
              end
            end
            PH_SHOW, PH_ZPOST: begin
              lamps_nxt = 4'd0;
              if (nibbles_r == 4'd0) begin
                phase_nxt = PH_IDLE; ticks_nxt = 16'd0; fin = 1'b1;
              end else if (nibbles_r[0]) begin
                // odd count done: gap inside a byte
                phase_nxt = PH_NGAP; ticks_nxt = cfg.nibble_gap_ms;
              end else if (mode_r == MODE_32 && nibbles_r == 4'd4) begin
                phase_nxt = PH_WPRE; ticks_nxt = cfg.word_gap_ms;
              end else begin
                phase_nxt = PH_BPRE; ticks_nxt = cfg.nibble_gap_ms;
              end
            end
            PH_ZPRE, PH_BPRE, PH_WPRE: begin
              lamp_nxt  = 2'd0;
              lamps_nxt = 4'b0001;
              ticks_nxt = cfg.zip_step_ms;
              case (phase_r)
                PH_ZPRE: begin zips_nxt = 3'd1; phase_nxt = PH_ZNIB; end
                PH_BPRE: begin zips_nxt = 3'd3; phase_nxt = PH_BZIP; end
                default: begin zips_nxt = 3'd6; phase_nxt = PH_WZIP; end
              endcase
            end
            PH_ZNIB, PH_BZIP, PH_WZIP: begin
              lamp_nxt = lamp_inc;
              if (wrap) zips_nxt = zips_dec;
              if (last_zip) begin
                lamps_nxt = 4'd0;
                case (phase_r)
                  PH_ZNIB: begin phase_nxt = PH_ZPOST; ticks_nxt = cfg.zero_frame_ms; end
                  PH_BZIP: begin phase_nxt = PH_BPOST; ticks_nxt = cfg.nibble_gap_ms; end
                  default: begin phase_nxt = PH_WPOST; ticks_nxt = cfg.word_gap_ms; end
                endcase
              end else begin
                lamps_nxt = 4'b0001 << lamp_inc;
                ticks_nxt = cfg.zip_step_ms;
              end
            end
            default: begin
              phase_nxt = PH_IDLE; lamps_nxt = 4'd0; ticks_nxt = 16'd0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      ticks_r   <= 16'd0;
      shift_r   <= 32'd0;
      nibbles_r <= 4'd0;
      lamp_r    <= 2'd0;
      zips_r    <= 3'd0;
      mode_r    <= MODE_8;
      lamps_r   <= 4'd0;
    end else begin
      phase_r   <= phase_nxt;
      ticks_r   <= ticks_nxt;
      shift_r   <= shift_nxt;
      nibbles_r <= nibbles_nxt;
      lamp_r    <= lamp_nxt;
      zips_r    <= zips_nxt;
      mode_r    <= mode_nxt;
      lamps_r   <= lamps_nxt;
    end
  end

  assign res.led_pattern = lamps_nxt;
  assign res.busy_res    = (phase_nxt != PH_IDLE);
  assign res.finished    = fin;

  `LNBS_ASSERT_NXT(a_fin_idle, fin, phase_r == PH_IDLE && lamps_r == 4'd0, "finish not idle")
  `LNBS_ASSERT_IMP(a_idle_dark, phase_r == PH_IDLE, lamps_r == 4'd0, "lamps lit while idle")
  `LNBS_ASSERT_IMP(a_zip_onehot,
    phase_r == PH_ZNIB || phase_r == PH_BZIP || phase_r == PH_WZIP,
    $onehot(lamps_r), "zip lamps not one-hot")

endmodule
`default_nettype wire

[sv/led_nibble_blink_sequencer.sv]
// Top level: input word register, sequencer core, result register.
// Depends on lnbs_pkg, lnbs_cfg, lnbs_core and assert_macros.svh.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_stall + op, value, width    | word in
//  out     | out_valid/out_stall + leds, busy, finish| word out
//  cfg     | cfg_we, cfg_index, cfg_data             | write only
//
// One word per cycle sustained while out_stall is low; out_valid rises once the held input word steps.
// The step itself is a 16 bit tick countdown plus a phase mux between the
// input register and the result register.
// Reset (synchronous, rst_n low) idles the sequencer and loads default durations.
// in_stall rises only when an input word is held and the result register is stalled.
`default_nettype none
module led_nibble_blink_sequencer (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire                             in_op,
  input  wire [31:0]                      in_value_in,
  input  wire [1:0]                       in_width_sel,
  input  wire                             in_start_pause,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [3:0]                      out_led_pattern,
  output logic                            out_busy_res,
  output logic                            out_finished,
  input  wire                             cfg_we,
  input  wire [lnbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [lnbs_pkg::DUR_W-1:0]       cfg_data
);
  import lnbs_pkg::*;
  `include "assert_macros.svh"

  logic      in_v_r, in_v_nxt;
  in_word_t  in_w_r;
  logic      out_v_r, out_v_nxt;
  res_word_t out_w_r;
  res_word_t res;
  cfg_t      cfg;
  logic      adv, accept;

  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_v_nxt  = accept ? 1'b1 : (adv ? 1'b0 : in_v_r);
    out_v_nxt = adv ? 1'b1 : (out_stall ? out_v_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_w_r.op          <= in_op;
      in_w_r.value_in    <= in_value_in;
      in_w_r.width_sel   <= in_width_sel;
      in_w_r.start_pause <= in_start_pause;
    end
    if (adv) out_w_r <= res;
  end

  lnbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lnbs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (adv),
    .word  (in_w_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_valid       = out_v_r;
  assign out_led_pattern = out_w_r.led_pattern;
  assign out_busy_res    = out_w_r.busy_res;
  assign out_finished    = out_w_r.finished;

  `LNBS_ASSERT_NXT(a_in_hold, in_v_r && !adv, in_v_r, "held input word dropped")
  `LNBS_ASSERT_NXT(a_adv_out, adv, out_v_r, "stepped word not presented")
  `LNBS_ASSERT_IMP(a_stall_cause, in_stall, out_v_r && out_stall, "input stalled without cause")

endmodule
`default_nettype wire
